// ----- rtl/s0pmp_pkg.sv -----
// shared types and constants of the pulse message parser
package s0pmp_pkg;

   localparam int CHAN_W = 3;

   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_ABORT = 1'b1;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [4:0] FIELD_COUNT_MAX = 5'd31;
   localparam logic [4:0] ID_FIELD        = 5'd1;
   localparam int         DATA_START      = 5;
   localparam int         DATA_STEP       = 3;

   typedef enum logic [1:0] {
      PH_SKIP = 2'd0,
      PH_READ = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   typedef struct packed {
      logic              take;
      logic              load_out;
      logic              clear_msg;
      logic [CHAN_W-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic end_ok;
      logic sel_emit;
      logic more_emit;
      logic out_free;
   } dp_sts_type;

endpackage

// ----- rtl/s0pmp_dpath.sv -----
// datapath: byte parser, field values, channel counts and result register
module s0pmp_dpath #(
   parameter int CHANNELS    = 5,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data,
   input  logic                        req_kind,
   input  logic [7:0]                  req_rx_byte,
   input  logic                        rsp_stall,
   input  s0pmp_pkg::dp_cmd_type       cmd,
   output s0pmp_pkg::dp_sts_type       sts,
   output logic                        rsp_valid,
   output logic [s0pmp_pkg::CHAN_W-1:0] rsp_channel,
   output logic [31:0]                 rsp_device_id,
   output logic [31:0]                 rsp_pulses,
   output logic                        rsp_last
);
   import s0pmp_pkg::*;

   localparam int XW     = COUNT_WIDTH + 4;
   localparam int OUT_W  = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
   localparam logic [4:0] FIELDS_EXPECTED = 5'(4 + DATA_STEP * CHANNELS);

   logic                   send_zero_ff;
   logic [4:0]             field_count_ff, field_count_in;
   logic                   inside_ff, inside_in;
   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0] id_ff, id_in;
   logic [COUNT_WIDTH-1:0] counts_ff [CHANNELS];
   logic [COUNT_WIDTH-1:0] counts_in [CHANNELS];
   logic                   prev_nl_ff, prev_nl_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]      rsp_channel_ff;
   logic [31:0]            rsp_device_id_ff;
   logic [31:0]            rsp_pulses_ff;
   logic                   rsp_last_ff;

   logic                   is_digit, is_space, is_lf, is_end, do_clear;
   logic                   close_en;
   logic [3:0]             digit;
   logic [XW-1:0]          acc_x10;
   logic [CHANNELS-1:0]    emit_mask;
   logic [COUNT_WIDTH-1:0] sel_count;

   always_comb begin
      is_digit = (req_rx_byte >= CH_ZERO) && (req_rx_byte <= CH_NINE);
      is_space = (req_rx_byte == CH_SPACE) ||
                 ((req_rx_byte >= CH_TAB) && (req_rx_byte <= CH_CR));
      is_lf    = (req_rx_byte == CH_LF);
      digit    = 4'(req_rx_byte - CH_ZERO);
   end

   // which channels produce a result, and selection by the walk index
   always_comb begin
      sel_count     = '0;
      sts.sel_emit  = 1'b0;
      sts.more_emit = 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
         emit_mask[k] = (counts_ff[k] != '0) || send_zero_ff;
         if (cmd.idx == CHAN_W'(k)) begin
            sel_count    = counts_ff[k];
            sts.sel_emit = emit_mask[k];
         end
         if (CHAN_W'(k) > cmd.idx && emit_mask[k]) begin
            sts.more_emit = 1'b1;
         end
      end
   end

   always_comb begin
      field_count_in = field_count_ff;
      inside_in      = inside_ff;
      phase_in       = phase_ff;
      acc_in         = acc_ff;
      id_in          = id_ff;
      counts_in      = counts_ff;
      prev_nl_in     = prev_nl_ff;
      close_en       = 1'b0;
      is_end         = 1'b0;
      acc_x10        = '0;

      if (cmd.take && req_kind == KIND_BYTE) begin
         if (req_rx_byte == CH_COLON) begin
            close_en   = inside_ff;
            prev_nl_in = 1'b0;
         end else begin
            // first byte of a field starts a fresh number
            if (!inside_ff) begin
               phase_in = PH_SKIP;
               acc_in   = '0;
            end
            inside_in = 1'b1;
            acc_x10   = (XW'(acc_in) << 3) + (XW'(acc_in) << 1) + XW'(digit);
            unique case (phase_in)
               PH_SKIP: begin
                  if (is_space) begin
                     phase_in = PH_SKIP;
                  end else if (req_rx_byte == CH_PLUS) begin
                     phase_in = PH_READ;
                  end else if (is_digit) begin
                     acc_in   = COUNT_WIDTH'(digit);
                     phase_in = PH_READ;
                  end else begin
                     acc_in   = '0;
                     phase_in = PH_DONE;
                  end
               end
               PH_READ: begin
                  if (is_digit) begin
                     // saturate once the value spills over the count width
                     if (acc_x10[XW-1:COUNT_WIDTH] != '0) begin
                        acc_in = '1;
                     end else begin
                        acc_in = acc_x10[COUNT_WIDTH-1:0];
                     end
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DONE: begin
                  phase_in = PH_DONE;
               end
               default: begin
                  phase_in = phase_in;
               end
            endcase
            if (is_lf && prev_nl_ff) begin
               close_en = 1'b1;
               is_end   = 1'b1;
            end else begin
               prev_nl_in = is_lf;
            end
         end
      end

      if (close_en) begin
         if (field_count_ff == ID_FIELD) begin
            id_in = acc_in;
         end
         for (int k = 0; k < CHANNELS; k++) begin
            if (field_count_ff == 5'(DATA_START + DATA_STEP * k)) begin
               counts_in[k] = acc_in;
            end
         end
         if (field_count_ff != FIELD_COUNT_MAX) begin
            field_count_in = field_count_ff + 5'd1;
         end
         inside_in = 1'b0;
      end

      sts.end_ok = is_end && (field_count_in == FIELDS_EXPECTED) && (emit_mask != '0);
      do_clear   = (cmd.take && req_kind == KIND_ABORT) || (is_end && !sts.end_ok) ||
                   cmd.clear_msg;
      if (do_clear) begin
         field_count_in = '0;
         inside_in      = 1'b0;
         phase_in       = PH_SKIP;
         acc_in         = '0;
         id_in          = '0;
         prev_nl_in     = 1'b0;
         for (int k = 0; k < CHANNELS; k++) begin
            counts_in[k] = '0;
         end
      end
   end

   always_comb begin
      sts.out_free = !rsp_valid_ff || !rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_zero_ff   <= 1'b0;
         field_count_ff <= '0;
         inside_ff      <= 1'b0;
         phase_ff       <= PH_SKIP;
         acc_ff         <= '0;
         id_ff          <= '0;
         prev_nl_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int k = 0; k < CHANNELS; k++) begin
            counts_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            send_zero_ff <= csr_wr_data;
         end
         field_count_ff <= field_count_in;
         inside_ff      <= inside_in;
         phase_ff       <= phase_in;
         acc_ff         <= acc_in;
         id_ff          <= id_in;
         prev_nl_ff     <= prev_nl_in;
         rsp_valid_ff   <= rsp_valid_in;
         counts_ff      <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_channel_ff   <= cmd.idx;
         rsp_device_id_ff <= 32'(id_ff[OUT_W-1:0]);
         rsp_pulses_ff    <= 32'(sel_count[OUT_W-1:0]);
         rsp_last_ff      <= !sts.more_emit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_channel   = rsp_channel_ff;
   assign rsp_device_id = rsp_device_id_ff;
   assign rsp_pulses    = rsp_pulses_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- rtl/s0pmp_ctrl.sv -----
// controller: request intake and walk over the channels of an accepted message
module s0pmp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  s0pmp_pkg::dp_sts_type sts,
   output s0pmp_pkg::dp_cmd_type cmd
);
   import s0pmp_pkg::*;

   typedef enum logic {
      ST_RUN,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [CHAN_W-1:0] idx_ff;
   logic              stall_ff;

   always_comb begin
      cmd.take      = req_valid && !stall_ff;
      cmd.idx       = idx_ff;
      cmd.load_out  = 1'b0;
      cmd.clear_msg = 1'b0;
      if (state_ff == ST_EMIT && sts.sel_emit && sts.out_free) begin
         cmd.load_out  = 1'b1;
         cmd.clear_msg = !sts.more_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         idx_ff   <= '0;
         stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_RUN: begin
               if (sts.end_ok) begin
                  state_ff <= ST_EMIT;
                  idx_ff   <= '0;
                  stall_ff <= 1'b1;
               end
            end
            ST_EMIT: begin
               // channels without a result are skipped one per cycle
               if (!sts.sel_emit) begin
                  idx_ff <= idx_ff + 1'b1;
               end else if (sts.out_free) begin
                  if (sts.more_emit) begin
                     idx_ff <= idx_ff + 1'b1;
                  end else begin
                     state_ff <= ST_RUN;
                     stall_ff <= 1'b0;
                  end
               end
            end
            default: begin
               state_ff <= ST_RUN;
            end
         endcase
      end
   end

   assign req_stall = stall_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded over a pending one");

   a_end_stalls: assert property (@(posedge clock) disable iff (reset)
      sts.end_ok |=> (state_ff == ST_EMIT) && req_stall)
      else $error("accepted message did not start the channel walk");

   a_end_taken: assert property (@(posedge clock) disable iff (reset)
      sts.end_ok |-> cmd.take)
      else $error("message end without an accepted request");

   a_clear_resume: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_msg |=> !req_stall)
      else $error("intake not resumed after final result");

endmodule

// ----- rtl/s0_pulse_message_parser.sv -----
// top level of the pulse meter message parser
//
//  port group   direction  handshake          contents
//  req_*        in         valid / stall      kind, rx_byte
//  rsp_*        out        valid / stall      channel, device_id, pulses, last
//  csr_*        in         write enable       send_zero
//
// one request per cycle while a message is being received.
// after the closing newline pair of an accepted message the request side stalls
// while the controller walks the channels, one channel per cycle unless the
// result side stalls.
// intake resumes as soon as the final result is in the output register.
// synchronous reset clears all message state and send_zero.
module s0_pulse_message_parser #(
   parameter int CHANNELS    = 5,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [7:0]                   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [s0pmp_pkg::CHAN_W-1:0] rsp_channel,
   output logic [31:0]                  rsp_device_id,
   output logic [31:0]                  rsp_pulses,
   output logic                         rsp_last
);
   import s0pmp_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   s0pmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   s0pmp_dpath #(
      .CHANNELS    (CHANNELS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_kind      (req_kind),
      .req_rx_byte   (req_rx_byte),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_channel   (rsp_channel),
      .rsp_device_id (rsp_device_id),
      .rsp_pulses    (rsp_pulses),
      .rsp_last      (rsp_last)
   );

endmodule
